[sv/bchd_pkg.sv]
`timescale 1ns / 1ps

package bchd_pkg;

  // Time stamp width default; the port field itself is fixed at 32 bits
  localparam int TIME_BITS_DEFAULT = 32;
  localparam int NOW_W   = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int EVENT_W = 3;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd25;
  localparam logic [CFG_W-1:0] GAP_RST       = 16'd250;
  localparam logic [CFG_W-1:0] HOLD_RST      = 16'd2000;
  localparam logic [CFG_W-1:0] LONG_HOLD_RST = 16'd4000;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_HOLD   = 3'd3,
    EV_LONG   = 3'd4
  } btn_event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_GAP       = 2'd1,
    CFG_HOLD      = 2'd2,
    CFG_LONG_HOLD = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] double_click_gap;
    logic [CFG_W-1:0] hold_time;
    logic [CFG_W-1:0] long_hold_time;
  } cfg_t;

endpackage

[sv/bchd_poll_if.sv]
`timescale 1ns / 1ps

interface bchd_poll_if;
  logic        valid;
  logic        ready;
  logic        button_level;
  logic [31:0] now_time;

  modport source (output valid, output button_level, output now_time, input ready);
  modport sink (input valid, input button_level, input now_time, output ready);
endinterface

[sv/bchd_event_if.sv]
`timescale 1ns / 1ps

interface bchd_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] button_event;

  modport source (output valid, output button_event, input ready);
  modport sink (input valid, input button_event, output ready);
endinterface

[sv/bchd_core.sv]
`timescale 1ns / 1ps

module bchd_core import bchd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 level,
  input  logic [TIME_BITS-1:0] now,
  input  cfg_t                 cfg,
  output btn_event_t           ev
);

  // Tracking state
  logic                 previous_level;
  btn_event_t           previous_event;
  logic                 waiting_second_click;
  logic                 double_on_release;
  logic                 single_allowed;
  logic [TIME_BITS-1:0] press_time;
  logic [TIME_BITS-1:0] release_time;
  logic                 ignore_release;
  logic                 hold_reported;
  logic                 long_hold_reported;

  logic                 waiting_second_click_next;
  logic                 double_on_release_next;
  logic                 single_allowed_next;
  logic [TIME_BITS-1:0] press_time_next;
  logic [TIME_BITS-1:0] release_time_next;
  logic                 ignore_release_next;
  logic                 hold_reported_next;
  logic                 long_hold_reported_next;

  logic [TIME_BITS-1:0] since_release;
  logic [TIME_BITS-1:0] since_press;
  logic [TIME_BITS-1:0] since_release_upd;
  logic [TIME_BITS-1:0] since_press_upd;
  logic [TIME_BITS-1:0] debounce_w;
  logic [TIME_BITS-1:0] gap_w;
  logic [TIME_BITS-1:0] hold_w;
  logic [TIME_BITS-1:0] long_w;
  logic                 press_edge;
  logic                 release_edge;
  logic                 release_taken;

  assign debounce_w = TIME_BITS'(cfg.debounce_time);
  assign gap_w      = TIME_BITS'(cfg.double_click_gap);
  assign hold_w     = TIME_BITS'(cfg.hold_time);
  assign long_w     = TIME_BITS'(cfg.long_hold_time);

  // Wrapping elapsed times against the stored edges
  assign since_release = now - release_time;
  assign since_press   = now - press_time;

  assign press_edge    = level && !previous_level && (since_release > debounce_w);
  assign release_edge  = !level && previous_level && (since_press > debounce_w);
  assign release_taken = !press_edge && release_edge && !ignore_release;

  // A freshly stored edge time reads as zero elapsed
  assign since_release_upd = release_taken ? '0 : since_release;
  assign since_press_upd   = press_edge ? '0 : since_press;

  // Event decision for one poll
  always_comb begin
    waiting_second_click_next = waiting_second_click;
    double_on_release_next    = double_on_release;
    single_allowed_next       = single_allowed;
    press_time_next           = press_time;
    release_time_next         = release_time;
    ignore_release_next       = ignore_release;
    hold_reported_next        = hold_reported;
    long_hold_reported_next   = long_hold_reported;
    ev                        = EV_NONE;

    // edge handling
    if (press_edge) begin
      press_time_next           = now;
      ignore_release_next       = 1'b0;
      hold_reported_next        = 1'b0;
      long_hold_reported_next   = 1'b0;
      single_allowed_next       = 1'b1;
      double_on_release_next    = (since_release < gap_w) && !double_on_release &&
                                  waiting_second_click;
      waiting_second_click_next = 1'b0;
    end else if (release_taken) begin
      release_time_next = now;
      if (!double_on_release) begin
        waiting_second_click_next = 1'b1;
      end else begin
        ev                        = EV_DOUBLE;
        double_on_release_next    = 1'b0;
        waiting_second_click_next = 1'b0;
        single_allowed_next       = 1'b0;
      end
    end

    // single click once the gap expires
    if (!level && (since_release_upd >= gap_w) && waiting_second_click_next &&
        !double_on_release_next && single_allowed_next && (ev != EV_DOUBLE)) begin
      ev                        = EV_CLICK;
      waiting_second_click_next = 1'b0;
    end

    // hold and long hold
    if (level && (since_press_upd >= hold_w)) begin
      if (!hold_reported_next) begin
        ev                        = EV_HOLD;
        double_on_release_next    = 1'b0;
        waiting_second_click_next = 1'b0;
        ignore_release_next       = 1'b1;
        hold_reported_next        = 1'b1;
      end
      if ((since_press_upd >= long_w) && !long_hold_reported_next) begin
        ev                      = EV_LONG;
        long_hold_reported_next = 1'b1;
      end
    end

    // repeat the last hold event while pressed
    if (level && (ev != EV_HOLD) && (ev != EV_LONG) &&
        ((previous_event == EV_HOLD) || (previous_event == EV_LONG))) begin
      ev = previous_event;
    end
  end

  // State update on each processed poll
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level       <= 1'b0;
      previous_event       <= EV_NONE;
      waiting_second_click <= 1'b0;
      double_on_release    <= 1'b0;
      single_allowed       <= 1'b1;
      press_time           <= '1;
      release_time         <= '1;
      ignore_release       <= 1'b0;
      hold_reported        <= 1'b0;
      long_hold_reported   <= 1'b0;
    end else if (step) begin
      previous_level       <= level;
      previous_event       <= ev;
      waiting_second_click <= waiting_second_click_next;
      double_on_release    <= double_on_release_next;
      single_allowed       <= single_allowed_next;
      press_time           <= press_time_next;
      release_time         <= release_time_next;
      ignore_release       <= ignore_release_next;
      hold_reported        <= hold_reported_next;
      long_hold_reported   <= long_hold_reported_next;
    end
  end

endmodule

[sv/button_click_hold_detector_top.sv]
`timescale 1ns / 1ps
// An accepted poll word fills the input register, its event word the result register.
// Throughput: one poll per cycle; the input register feeds the event logic and
// the result register in the same cycle, and a stalled result holds both stages.
// Reset (rst, synchronous, active high) clears the pipeline valids, the
// tracking state and loads the default debounce, gap and hold times.

module button_click_hold_detector_top import bchd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bchd_poll_if.sink            poll,
  bchd_event_if.source         result
);

  cfg_t                 cfg;
  logic                 in_valid;
  logic                 in_level;
  logic [NOW_W-1:0]     in_now;
  logic                 out_valid;
  btn_event_t           out_event;
  logic                 advance;
  btn_event_t           ev;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time    <= DEBOUNCE_RST;
      cfg.double_click_gap <= GAP_RST;
      cfg.hold_time        <= HOLD_RST;
      cfg.long_hold_time   <= LONG_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE:  cfg.debounce_time    <= cfg_data;
        CFG_GAP:       cfg.double_click_gap <= cfg_data;
        CFG_HOLD:      cfg.hold_time        <= cfg_data;
        CFG_LONG_HOLD: cfg.long_hold_time   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline moves whenever the result register is free or being taken
  assign advance    = !out_valid || result.ready;
  assign poll.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.ready && poll.valid) begin
      in_level <= poll.button_level;
      in_now   <= poll.now_time;
    end
  end

  bchd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (in_valid && advance),
    .level (in_level),
    .now   (TIME_BITS'(in_now)),
    .cfg   (cfg),
    .ev    (ev)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_event <= ev;
    end
  end

  assign result.valid        = out_valid;
  assign result.button_event = out_event;

endmodule

[sv/bchd_checker.sv]
`timescale 1ns / 1ps

module bchd_checker import bchd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               poll_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic [EVENT_W-1:0] button_event
);

  // Only defined event codes leave the block
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (button_event <= EV_LONG))
    else $error("undefined event code");

  // Nothing comes out right after reset
  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid after reset");

  // An empty result register never blocks the poll side
  assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> poll_ready)
    else $error("poll stalled with empty output");

  // A stalled event word holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(button_event))
    else $error("stalled event changed");

endmodule

bind button_click_hold_detector_top bchd_checker u_bchd_checker (
  .clk          (clk),
  .rst          (rst),
  .poll_ready   (poll.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .button_event (result.button_event)
);
